[hdl/asd_pkg.sv]
// asd_pkg: shared types, constants and helpers for the step detector.
// No dependencies; used by every module in hdl/.
package asd_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int ADC_BITS    = 12;
  localparam int MAG_W       = 12;
  localparam int SUM_W       = 2 * ADC_BITS;
  localparam int REM_W       = ADC_BITS + 4;
  localparam int LP_W        = 17;
  localparam int HP_W        = 24;
  localparam int F_W         = 16;
  localparam int CNT_W       = 4;
  localparam int PADDR_W     = 5;

  localparam logic [LP_W-1:0]       LP_RESET = LP_W'(40832);
  localparam logic signed [HP_W-1:0] HP_RESET = HP_W'(32866);
  localparam logic signed [F_W-1:0]  MID      = F_W'(2048);
  localparam logic [LP_W-1:0]       S_OFFSET = LP_W'(2048 * 16);

  typedef enum logic [2:0] {
    REG_DETECT_METHOD  = 3'd0,
    REG_SWIM_SELECT    = 3'd1,
    REG_HIGH_THRESHOLD = 3'd2,
    REG_LOW_THRESHOLD  = 3'd3,
    REG_DEBOUNCE_LEN   = 3'd4,
    REG_GAP_MIN        = 3'd5,
    REG_GAP_MAX        = 3'd6,
    REG_PEAK_THRESHOLD = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [11:0] x_raw;
    logic [11:0] y_raw;
    logic [11:0] z_raw;
    logic [15:0] tick_time;
    logic        count_enable;
  } in_t;

  typedef struct packed {
    logic [31:0] step_count;
    logic        step_counted;
    logic [11:0] magnitude;
  } out_t;

  typedef struct packed {
    logic        detect_method;
    logic        swim_select;
    logic [11:0] high_threshold;
    logic [11:0] low_threshold;
    logic [3:0]  debounce_len;
    logic [15:0] gap_min;
    logic [15:0] gap_max;
    logic [11:0] peak_threshold;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       sq;
    logic [1:0] axis;
    logic       rload;
    logic       rstep;
    logic       fa;
    logic       fb;
    logic       fc;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

  // One high-pass stage: (t*15 + 0x8000 + 8) / 16, truncating, wrapped to 24 bits.
  function automatic logic signed [HP_W-1:0] hp_stage(input logic signed [HP_W+1:0] t);
    logic signed [31:0] p;
    logic signed [31:0] q;
    begin
      p = (32'(t) <<< 4) - 32'(t) + 32'sd32776;
      q = p >>> 4;
      if (p < 0 && p[3:0] != 4'd0) begin
        q = q + 32'sd1;
      end
      return q[HP_W-1:0];
    end
  endfunction

endpackage

[hdl/asd_ctrl.sv]
// asd_ctrl: sequencer for one sample (squares, root, filter, settle, commit).
// Depends on asd_pkg.
module asd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  asd_pkg::sts_t sts,
  output asd_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_RLOAD, S_ROOT, S_FA, S_FB, S_FC, S_FD, S_DONE
  } state_t;

  state_t                    state_r;
  logic [asd_pkg::CNT_W-1:0] cnt_r;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.load   = in_valid && (state_r == S_IDLE);
    cmd.sq     = (state_r == S_SQ);
    cmd.axis   = cnt_r[1:0];
    cmd.rload  = (state_r == S_RLOAD);
    cmd.rstep  = (state_r == S_ROOT);
    cmd.fa     = (state_r == S_FA);
    cmd.fb     = (state_r == S_FB);
    cmd.fc     = (state_r == S_FC);
    cmd.commit = (state_r == S_DONE) && !sts.out_busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          if (in_valid) state_r <= S_SQ;
        end
        S_SQ: begin
          if (cnt_r == asd_pkg::CNT_W'(2)) begin
            cnt_r   <= '0;
            state_r <= S_RLOAD;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_RLOAD: state_r <= S_ROOT;
        S_ROOT: begin
          if (cnt_r == asd_pkg::CNT_W'(asd_pkg::ADC_BITS - 1)) begin
            cnt_r   <= '0;
            state_r <= S_FA;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_FA: state_r <= S_FB;
        S_FB: state_r <= S_FC;
        S_FC: state_r <= S_FD;
        // second high-pass stage settles into h2/f registers
        S_FD: state_r <= S_DONE;
        S_DONE: begin
          if (!sts.out_busy) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/asd_dp.sv]
// asd_dp: magnitude, filters, step detection state and result register.
// Depends on asd_pkg; driven by asd_ctrl commands.
module asd_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  asd_pkg::cmd_t cmd,
  output asd_pkg::sts_t sts,
  input  asd_pkg::cfg_t cfg,
  input  asd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output asd_pkg::out_t out_data
);

  localparam int AX_W = asd_pkg::ADC_BITS + 1;
  localparam logic signed [AX_W-1:0] HALF = AX_W'(1 << (asd_pkg::ADC_BITS - 1));

  // captured request
  asd_pkg::in_t smp_r;

  // magnitude path
  logic signed [AX_W-1:0]       ax, ay, az, op;
  logic signed [2*AX_W-1:0]     prod;
  logic [asd_pkg::SUM_W-1:0]    sum_r, rad_r;
  logic [asd_pkg::REM_W-1:0]    rem_r, rem_sh, trial;
  logic [asd_pkg::ADC_BITS-1:0] root_r;

  // filter pipeline
  logic [asd_pkg::LP_W-1:0]          s_val, l1_r, l2_r;
  logic [asd_pkg::LP_W:0]            l1_sum, l2_sum;
  logic signed [asd_pkg::HP_W-1:0]   h1_r, h2_r;
  logic signed [asd_pkg::HP_W+1:0]   t1, t2;
  logic signed [asd_pkg::F_W-1:0]    f_r;

  // detector state
  logic                             low_phase_r, low_phase_nxt;
  logic [3:0]                       deb_r, deb_nxt, deb_inc;
  logic [15:0]                      last_r, last_nxt, gap_d;
  logic [asd_pkg::COUNT_WIDTH-1:0]  walk_r, walk_nxt, swim_r, swim_nxt;
  logic [asd_pkg::LP_W-1:0]         lp1_r, lp2_r;
  logic signed [asd_pkg::HP_W-1:0]  hp1_r, hp2_r;
  logic signed [asd_pkg::F_W-1:0]   prev_r, crest_r, crest_nxt, trough_r, trough_nxt;
  logic                             rise_r, rise_nxt, fall_r, fall_nxt;
  logic                             detect, counted, qualify, gap_ok;
  logic signed [asd_pkg::F_W:0]     depth;

  logic          out_valid_r;
  asd_pkg::out_t out_r;

  assign ax = signed'({1'b0, smp_r.x_raw[asd_pkg::ADC_BITS-1:0]}) - HALF;
  assign ay = signed'({1'b0, smp_r.y_raw[asd_pkg::ADC_BITS-1:0]}) - HALF;
  assign az = signed'({1'b0, smp_r.z_raw[asd_pkg::ADC_BITS-1:0]}) - HALF;

  always_comb begin
    unique case (cmd.axis)
      2'd0:    op = ax;
      2'd1:    op = ay;
      default: op = az;
    endcase
  end

  assign prod   = op * op;
  assign rem_sh = {rem_r[asd_pkg::REM_W-3:0], rad_r[asd_pkg::SUM_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};

  assign s_val  = asd_pkg::LP_W'({root_r, 4'b0000}) + asd_pkg::S_OFFSET;
  assign l1_sum = {1'b0, lp1_r} + {1'b0, s_val} + 1'b1;
  assign l2_sum = {1'b0, lp2_r} + {1'b0, l1_r} + 1'b1;
  assign t1 = (asd_pkg::HP_W+2)'(hp1_r) + signed'({9'b0, l2_r}) - signed'({9'b0, lp2_r});
  assign t2 = (asd_pkg::HP_W+2)'(hp2_r) + (asd_pkg::HP_W+2)'(h1_r)
            - (asd_pkg::HP_W+2)'(hp1_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_r <= in_data;
      sum_r <= '0;
    end
    if (cmd.sq) sum_r <= sum_r + prod[asd_pkg::SUM_W-1:0];
    if (cmd.rload) begin
      rad_r  <= sum_r;
      rem_r  <= '0;
      root_r <= '0;
    end
    if (cmd.rstep) begin
      rad_r <= {rad_r[asd_pkg::SUM_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[asd_pkg::ADC_BITS-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[asd_pkg::ADC_BITS-2:0], 1'b0};
      end
    end
    if (cmd.fa) l1_r <= l1_sum[asd_pkg::LP_W:1];
    if (cmd.fb) begin
      l2_r <= l2_sum[asd_pkg::LP_W:1];
    end
    if (cmd.fc) h1_r <= asd_pkg::hp_stage(t1);
  end

  // second high-pass and filtered value, evaluated in the settle cycle after h1
  logic signed [asd_pkg::HP_W-1:0] h2_c;
  logic signed [asd_pkg::HP_W-1:0] hq2;
  logic signed [asd_pkg::F_W-1:0]  f_c;
  assign h2_c = asd_pkg::hp_stage(t2);
  always_comb begin
    hq2 = h2_c >>> 4;
    if (h2_c < 0 && h2_c[3:0] != 4'd0) hq2 = hq2 + 1'b1;
    f_c = hq2[asd_pkg::F_W-1:0];
  end

  // h2_r/f_r register the last filter step once h1 is ready
  logic f_ready_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_ready_r <= 1'b0;
    end else begin
      f_ready_r <= cmd.fc;
    end
    if (f_ready_r) begin
      h2_r <= h2_c;
      f_r  <= f_c;
    end
  end

  // commit: detection and counting
  assign gap_d  = smp_r.tick_time - last_r;
  assign gap_ok = (gap_d >= cfg.gap_min) && (gap_d <= cfg.gap_max);
  assign deb_inc = deb_r + 1'b1;

  always_comb begin
    low_phase_nxt = low_phase_r;
    deb_nxt       = deb_r;
    crest_nxt     = crest_r;
    trough_nxt    = trough_r;
    rise_nxt      = rise_r;
    fall_nxt      = fall_r;
    detect        = 1'b0;
    depth         = '0;
    qualify       = low_phase_r ? (root_r > cfg.high_threshold)
                                : (root_r < cfg.low_threshold);
    if (smp_r.count_enable && !cfg.detect_method) begin
      if (qualify) begin
        deb_nxt = deb_inc;
        if (deb_inc >= cfg.debounce_len) begin
          deb_nxt       = '0;
          low_phase_nxt = !low_phase_r;
          detect        = low_phase_r;
        end
      end else begin
        deb_nxt = '0;
      end
    end else if (smp_r.count_enable) begin
      if (f_r > asd_pkg::MID && f_r > crest_r) crest_nxt = f_r;
      if (f_r < asd_pkg::MID && f_r < trough_r) trough_nxt = f_r;
      if (f_r >= asd_pkg::MID && prev_r < asd_pkg::MID) begin
        depth      = 17'(asd_pkg::MID) - 17'(trough_nxt);
        trough_nxt = asd_pkg::MID;
        rise_nxt   = depth > signed'({5'b0, cfg.peak_threshold});
      end
      if (f_r <= asd_pkg::MID && prev_r > asd_pkg::MID) begin
        depth     = 17'(crest_nxt) - 17'(asd_pkg::MID);
        crest_nxt = asd_pkg::MID;
        fall_nxt  = depth > signed'({5'b0, cfg.peak_threshold});
      end
      if (rise_nxt && fall_nxt) begin
        rise_nxt = 1'b0;
        fall_nxt = 1'b0;
        detect   = 1'b1;
      end
    end
  end

  always_comb begin
    walk_nxt = walk_r;
    swim_nxt = swim_r;
    last_nxt = last_r;
    counted  = 1'b0;
    if (detect) begin
      if (gap_ok) begin
        counted  = 1'b1;
        last_nxt = '0;
        if (cfg.swim_select) swim_nxt = swim_r + 1'b1;
        else walk_nxt = walk_r + 1'b1;
      end else begin
        last_nxt = smp_r.tick_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_phase_r <= 1'b0;
      deb_r       <= '0;
      last_r      <= '0;
      walk_r      <= '0;
      swim_r      <= '0;
      lp1_r       <= asd_pkg::LP_RESET;
      lp2_r       <= asd_pkg::LP_RESET;
      hp1_r       <= asd_pkg::HP_RESET;
      hp2_r       <= asd_pkg::HP_RESET;
      prev_r      <= asd_pkg::MID;
      crest_r     <= asd_pkg::MID;
      trough_r    <= asd_pkg::MID;
      rise_r      <= 1'b0;
      fall_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        low_phase_r <= low_phase_nxt;
        deb_r       <= deb_nxt;
        last_r      <= last_nxt;
        walk_r      <= walk_nxt;
        swim_r      <= swim_nxt;
        crest_r     <= crest_nxt;
        trough_r    <= trough_nxt;
        rise_r      <= rise_nxt;
        fall_r      <= fall_nxt;
        if (smp_r.count_enable && cfg.detect_method) begin
          lp1_r  <= l1_r;
          lp2_r  <= l2_r;
          hp1_r  <= h1_r;
          hp2_r  <= h2_r;
          prev_r <= f_r;
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r.step_count   <= 32'(cfg.swim_select ? swim_nxt : walk_nxt);
      out_r.step_counted <= counted;
      out_r.magnitude    <= asd_pkg::MAG_W'(root_r);
    end
  end

  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule

[hdl/accel_step_detector.sv]
// accel_step_detector: three-axis step counter with APB-style register port.
// Each request runs through square, load, root, filter, settle and commit steps,
// in that order; commit waits while an earlier result is held and not yet taken.
// The serial sequence, mostly root, sets the rate: one request at a time.
// A new request is taken while the previous result still waits downstream.
// Reset (rst_n low, synchronous) restores registers and all detector state.
module accel_step_detector (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  asd_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output asd_pkg::out_t                out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [asd_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  asd_pkg::cfg_t     cfg_r;
  asd_pkg::cmd_t     cmd;
  asd_pkg::sts_t     sts;
  asd_pkg::reg_idx_t reg_idx;
  logic              wr_en;

  // register file: word-aligned, index in paddr[4:2]
  assign pready  = 1'b1;
  assign reg_idx = asd_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.detect_method  <= 1'b0;
      cfg_r.swim_select    <= 1'b0;
      cfg_r.high_threshold <= 12'd1124;
      cfg_r.low_threshold  <= 12'd924;
      cfg_r.debounce_len   <= 4'd1;
      cfg_r.gap_min        <= 16'd6;
      cfg_r.gap_max        <= 16'd67;
      cfg_r.peak_threshold <= 12'd100;
    end else if (wr_en) begin
      unique case (reg_idx)
        asd_pkg::REG_DETECT_METHOD:  cfg_r.detect_method  <= pwdata[0];
        asd_pkg::REG_SWIM_SELECT:    cfg_r.swim_select    <= pwdata[0];
        asd_pkg::REG_HIGH_THRESHOLD: cfg_r.high_threshold <= pwdata[11:0];
        asd_pkg::REG_LOW_THRESHOLD:  cfg_r.low_threshold  <= pwdata[11:0];
        asd_pkg::REG_DEBOUNCE_LEN:   cfg_r.debounce_len   <= pwdata[3:0];
        asd_pkg::REG_GAP_MIN:        cfg_r.gap_min        <= pwdata[15:0];
        asd_pkg::REG_GAP_MAX:        cfg_r.gap_max        <= pwdata[15:0];
        asd_pkg::REG_PEAK_THRESHOLD: cfg_r.peak_threshold <= pwdata[11:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      asd_pkg::REG_DETECT_METHOD:  prdata = 32'(cfg_r.detect_method);
      asd_pkg::REG_SWIM_SELECT:    prdata = 32'(cfg_r.swim_select);
      asd_pkg::REG_HIGH_THRESHOLD: prdata = 32'(cfg_r.high_threshold);
      asd_pkg::REG_LOW_THRESHOLD:  prdata = 32'(cfg_r.low_threshold);
      asd_pkg::REG_DEBOUNCE_LEN:   prdata = 32'(cfg_r.debounce_len);
      asd_pkg::REG_GAP_MIN:        prdata = 32'(cfg_r.gap_min);
      asd_pkg::REG_GAP_MAX:        prdata = 32'(cfg_r.gap_max);
      asd_pkg::REG_PEAK_THRESHOLD: prdata = 32'(cfg_r.peak_threshold);
    endcase
  end

  // sequencer: walks each request through square, root, filter and commit
  asd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: shared square unit, bit-serial root, filters, detector, output reg
  asd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // accepting a request always moves the sequencer out of idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sequencer stayed idle after accept");

  // a result is only written while the output register is free
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid && !out_ready))
    else $error("commit over a pending result");

  // a new result appears only after a commit
  a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result valid without commit");

endmodule
